[rtl/bdrl_pkg.sv]
// ----------------------------------------------------------------------------
// bdrl_pkg: shared types for the button debounce / remote latch block
// Button codes, the input beat and the result beat as packed structs.
// ----------------------------------------------------------------------------
package bdrl_pkg;

  typedef enum logic [1:0] {
    BTN_NONE  = 2'd0,
    BTN_OPEN  = 2'd1,
    BTN_CLOSE = 2'd2,
    BTN_BOTH  = 2'd3
  } bdrl_code_t;

  localparam logic [15:0] SETTLE_MS_RESET = 16'd50;

  typedef struct packed {
    logic        open_level;
    logic        close_level;
    logic        remote_valid;
    logic [31:0] remote_code;
    logic [31:0] now_ms;
    logic        consume_signal;
  } bdrl_item_t;

  typedef struct packed {
    bdrl_code_t  debounced_button;
    bdrl_code_t  last_press;
    logic [31:0] last_press_time;
    logic        remote_pending;
    logic [31:0] latest_remote_code;
    logic [31:0] remote_time;
    logic [31:0] idle_ms;
  } bdrl_result_t;

endpackage

[rtl/bdrl_core.sv]
// ----------------------------------------------------------------------------
// bdrl_core: debounce state and per-poll evaluation
// Holds the debounce, press and remote state; evaluates one poll per enable.
// ----------------------------------------------------------------------------
module bdrl_core
  import bdrl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         step,
  input  bdrl_item_t   item,
  output bdrl_result_t result
);

  logic [15:0] settle_ms;
  bdrl_code_t  raw_code;
  logic [31:0] edge_time;
  bdrl_code_t  stable_code;
  bdrl_code_t  press_code;
  logic [31:0] press_time;
  logic [31:0] remote_latch;
  logic [31:0] remote_stamp;
  logic        fresh_flag;

  bdrl_code_t  code;
  logic [31:0] edge_time_next;
  bdrl_code_t  stable_code_next;
  bdrl_code_t  press_code_next;
  logic [31:0] press_time_next;
  logic [31:0] remote_latch_next;
  logic [31:0] remote_stamp_next;
  logic        fresh_report;
  logic        fresh_flag_next;
  logic [31:0] held_ms;
  logic [31:0] latest;
  logic        settle;

  always_comb begin
    code              = bdrl_code_t'({item.close_level, item.open_level});
    remote_latch_next = item.remote_valid ? item.remote_code : remote_latch;
    remote_stamp_next = item.remote_valid ? item.now_ms : remote_stamp;
    fresh_report      = item.remote_valid | fresh_flag;
    fresh_flag_next   = fresh_report & ~item.consume_signal;

    // restart the edge timer on any change of the raw code
    edge_time_next = (code != raw_code) ? item.now_ms : edge_time;
    held_ms        = item.now_ms - edge_time_next;
    settle         = (stable_code != code) && (held_ms > {16'd0, settle_ms});

    stable_code_next = settle ? code : stable_code;
    press_code_next  = press_code;
    press_time_next  = press_time;
    if (settle && code != BTN_NONE) begin
      press_code_next = code;
      press_time_next = item.now_ms;
    end

    latest = (remote_stamp_next > press_time_next) ? remote_stamp_next : press_time_next;

    result.debounced_button   = stable_code_next;
    result.last_press         = press_code_next;
    result.last_press_time    = press_time_next;
    result.remote_pending     = fresh_report;
    result.latest_remote_code = remote_latch_next;
    result.remote_time        = remote_stamp_next;
    result.idle_ms            = (stable_code_next != BTN_NONE) ? 32'd0 : item.now_ms - latest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ms      <= SETTLE_MS_RESET;
      raw_code       <= BTN_NONE;
      edge_time      <= 32'd0;
      stable_code    <= BTN_NONE;
      press_code     <= BTN_NONE;
      press_time     <= 32'd0;
      remote_latch   <= 32'd0;
      remote_stamp   <= 32'd0;
      fresh_flag     <= 1'b0;
    end else begin
      if (cfg_we) begin
        settle_ms <= cfg_wdata;
      end
      if (step) begin
        raw_code     <= code;
        edge_time    <= edge_time_next;
        stable_code  <= stable_code_next;
        press_code   <= press_code_next;
        press_time   <= press_time_next;
        remote_latch <= remote_latch_next;
        remote_stamp <= remote_stamp_next;
        fresh_flag   <= fresh_flag_next;
      end
    end
  end

endmodule

[rtl/button_debounce_remote_latch_top.sv]
// ----------------------------------------------------------------------------
// button_debounce_remote_latch_top: timed button debouncer with remote latch
// Path: input register, core, result register.
// Throughput: one poll per cycle while out_stall is low; each register holds
// one beat, so a poll is taken while a result waits if the input one is free.
// Reset (rst, synchronous): empties both registers, clears all debounce,
// press and remote state, and loads the 50 ms debounce delay.
// ----------------------------------------------------------------------------
module button_debounce_remote_latch_top
  import bdrl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration: debounce delay in ms
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // poll channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        open_level,
  input  logic        close_level,
  input  logic        remote_valid,
  input  logic [31:0] remote_code,
  input  logic [31:0] now_ms,
  input  logic        consume_signal,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  debounced_button,
  output logic [1:0]  last_press,
  output logic [31:0] last_press_time,
  output logic        remote_pending,
  output logic [31:0] latest_remote_code,
  output logic [31:0] remote_time,
  output logic [31:0] idle_ms
);

  logic         in_reg_valid;
  bdrl_item_t   in_reg;
  bdrl_result_t result;
  bdrl_result_t out_reg;
  logic         advance;

  // Move the held poll into the result register when that register is free
  // or its beat is being taken this cycle.
  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  // Stall the poll side only when the input register is full and cannot move.
  assign in_stall = in_reg_valid && !advance;

  // Evaluate the held poll; debounce, press and remote state update only on the cycle it moves on.
  bdrl_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .item      (in_reg),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // input register: load on accept, drop when it advances
      if (in_valid && !in_stall) begin
        in_reg_valid <= 1'b1;
      end else if (advance) begin
        in_reg_valid <= 1'b0;
      end
      // result register: load on advance, drop once the beat is taken
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg.open_level     <= open_level;
      in_reg.close_level    <= close_level;
      in_reg.remote_valid   <= remote_valid;
      in_reg.remote_code    <= remote_code;
      in_reg.now_ms         <= now_ms;
      in_reg.consume_signal <= consume_signal;
    end
    if (advance) begin
      out_reg <= result;
    end
  end

  assign debounced_button   = out_reg.debounced_button;
  assign last_press         = out_reg.last_press;
  assign last_press_time    = out_reg.last_press_time;
  assign remote_pending     = out_reg.remote_pending;
  assign latest_remote_code = out_reg.latest_remote_code;
  assign remote_time        = out_reg.remote_time;
  assign idle_ms            = out_reg.idle_ms;

endmodule

[rtl/bdrl_checker.sv]
// ----------------------------------------------------------------------------
// bdrl_checker: port-level checks for the button debounce / remote latch
// Watches the result channel over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module bdrl_checker
  import bdrl_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  debounced_button,
  input logic [1:0]  last_press,
  input logic [31:0] idle_ms
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // a held button reports zero idle time
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && debounced_button != BTN_NONE |-> idle_ms == 32'd0)
    else $error("idle time nonzero while a button is held");

  // a held debounced code is also the last press
  a_press_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && debounced_button != BTN_NONE |-> last_press == debounced_button)
    else $error("last press differs from held debounced code");

endmodule

bind button_debounce_remote_latch_top bdrl_checker u_bdrl_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .debounced_button (debounced_button),
  .last_press       (last_press),
  .idle_ms          (idle_ms)
);
